// File: rtl/ict_pkg.sv
// Shared types, constants and helpers of the tilt filter.
package ict_pkg;

  localparam int ANGLE_FRAC_BITS = 16;
  localparam int ANG_SH          = 24 - ANGLE_FRAC_BITS;
  localparam int ANG_RND         = (ANG_SH == 0) ? 0 : (1 << (ANG_SH - 1));
  localparam int CORDIC_STEPS    = 24;
  localparam int CORDIC_PRE_SH   = 20;
  localparam int SQRT_STEPS      = 16;
  localparam int DIV_W           = 51;
  localparam int DIV_REM_W       = 10;
  localparam int DIV_DIG_W       = 16;
  localparam int DIV_STEPS       = 4;
  localparam int DIV_PAD_W       = DIV_DIG_W * DIV_STEPS;
  localparam int DIV_VAL_W       = DIV_REM_W + DIV_DIG_W;
  localparam int DIV_RECIP_SH    = 36;
  localparam logic [26:0]        DIV_RECIP = 27'd68719477;
  localparam logic [DIV_W-1:0]   DIV_HALF = 51'd500;
  localparam logic signed [32:0] DEG90_Q24 = 33'sd1509949440;
  localparam logic [16:0] WEIGHT_ONE = 17'd65536;

  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t REG_GAIN  = 3'd0;
  localparam cfg_idx_t REG_OFF_X = 3'd1;
  localparam cfg_idx_t REG_OFF_Y = 3'd2;
  localparam cfg_idx_t REG_OFF_Z = 3'd3;
  localparam cfg_idx_t REG_WEIGHT = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ_A, ST_SQ_B, ST_SQ_C, ST_SQRT_W, ST_CORD_W,
    ST_G1, ST_G2, ST_G3, ST_G4, ST_DIV_W,
    ST_B1, ST_B2, ST_B3, ST_B4, ST_B5
  } st_t;

  typedef struct packed {
    logic sq_start;
    logic cord_start;
    logic div_start;
  } unit_ctl_t;

  function automatic logic signed [32:0] atan_q24(input logic [4:0] i);
    case (i)
      5'd0:  atan_q24 = 33'sd754974720;
      5'd1:  atan_q24 = 33'sd445687602;
      5'd2:  atan_q24 = 33'sd235489088;
      5'd3:  atan_q24 = 33'sd119537938;
      5'd4:  atan_q24 = 33'sd60000934;
      5'd5:  atan_q24 = 33'sd30029717;
      5'd6:  atan_q24 = 33'sd15018523;
      5'd7:  atan_q24 = 33'sd7509720;
      5'd8:  atan_q24 = 33'sd3754917;
      5'd9:  atan_q24 = 33'sd1877466;
      5'd10: atan_q24 = 33'sd938734;
      5'd11: atan_q24 = 33'sd469367;
      5'd12: atan_q24 = 33'sd234684;
      5'd13: atan_q24 = 33'sd117342;
      5'd14: atan_q24 = 33'sd58671;
      5'd15: atan_q24 = 33'sd29335;
      5'd16: atan_q24 = 33'sd14668;
      5'd17: atan_q24 = 33'sd7334;
      5'd18: atan_q24 = 33'sd3667;
      5'd19: atan_q24 = 33'sd1833;
      5'd20: atan_q24 = 33'sd917;
      5'd21: atan_q24 = 33'sd458;
      5'd22: atan_q24 = 33'sd229;
      5'd23: atan_q24 = 33'sd115;
      default: atan_q24 = 33'sd0;
    endcase
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    if (v > 48'sd2147483647) begin
      sat32 = 32'sh7FFFFFFF;
    end else if (v < -48'sd2147483648) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = 32'(v);
    end
  endfunction

endpackage

// File: rtl/ict_if.sv
// Handshake channels of the tilt filter: sample in, angles out, register writes.
interface ict_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] acc_x;
  logic signed [15:0] acc_y;
  logic signed [15:0] acc_z;
  logic signed [15:0] rate_x;
  logic signed [15:0] rate_y;
  logic signed [15:0] rate_z;
  logic [15:0]        elapsed_ms;
  modport source(output valid, acc_x, acc_y, acc_z, rate_x, rate_y, rate_z, elapsed_ms,
                 input ready);
  modport sink(input valid, acc_x, acc_y, acc_z, rate_x, rate_y, rate_z, elapsed_ms,
               output ready);
endinterface

interface ict_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] tilt_x;
  logic signed [31:0] tilt_y;
  logic signed [31:0] heading_z;
  logic signed [24:0] acc_tilt_x;
  logic signed [24:0] acc_tilt_y;
  modport source(output valid, tilt_x, tilt_y, heading_z, acc_tilt_x, acc_tilt_y,
                 input ready);
  modport sink(input valid, tilt_x, tilt_y, heading_z, acc_tilt_x, acc_tilt_y,
               output ready);
endinterface

interface ict_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// File: rtl/imu_complementary_tilt_filter.sv
// Complementary-filter tilt estimator: sequencer, shared multiplier and state.
// Work per sample: two 16-step square roots, two 24-step CORDIC runs, three 4-digit
//   divides by 1000 and the multiply sequence; a CORDIC run skips its micro-rotations
//   when its accelerometer angle takes the zero or 90-degree shortcut.
// Flow: a sample is taken only when idle, not while one is in work; the next sample is
//   taken while a result waits; the last divide holds while an earlier result word is unaccepted.
// Reset: filter state zero, registers to their defaults, no result pending.
module imu_complementary_tilt_filter (
  input  logic     clk,
  input  logic     rst_n,
  ict_in_if.sink   in_ch,
  ict_out_if.source out_ch,
  ict_cfg_if.sink  cfg_ch
);
  import ict_pkg::*;

  st_t st_r, st_nxt;
  unit_ctl_t ctl;

  logic [23:0]        gain_r;
  logic signed [31:0] off_x_r, off_y_r, off_z_r;
  logic [16:0]        weight_r;
  logic signed [31:0] filt_x_r, filt_y_r, intz_r;
  logic signed [15:0] ax_r, ay_r, az_r, rx_r, ry_r, rz_r;
  logic [15:0]        ms_r;
  logic               phase_r;
  logic [1:0]         g_r;
  logic signed [24:0] ang_x_r, ang_y_r;
  logic signed [33:0] rate_r;
  logic               neg_r;
  logic signed [41:0] step_r;
  logic signed [42:0] s_r;
  logic signed [63:0] mac_r;
  logic signed [59:0] prod_r;

  logic               ov_r;
  logic signed [31:0] o_tx_r, o_ty_r, o_hz_r;
  logic signed [24:0] o_ax_r, o_ay_r;

  logic signed [34:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [15:0] a1, cnum, raw_g;
  logic signed [31:0] off_g, prev_g;
  logic signed [24:0] ang_g;
  logic [16:0]        w_eff, gw;
  logic [DIV_W-1:0]   div_num, quo;
  logic [59:0]        mag;
  logic signed [59:0] rnd;
  logic signed [47:0] blend_sh, zsum, hz_sum;
  logic [15:0]        root;
  logic signed [24:0] angle;
  logic               sq_done, cord_done, div_done, out_free, in_acc;
  logic               div_hold_r;
  logic signed [41:0] q_signed;
  logic               res_load;

  ict_isqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(ctl.sq_start),
    .v(mac_r[31:0] + prod_r[31:0]), .done(sq_done), .root(root)
  );

  ict_cordic u_cordic (
    .clk(clk), .rst_n(rst_n), .start(ctl.cord_start),
    .num(cnum), .den(root), .done(cord_done), .angle(angle)
  );

  ict_div1000 u_div (
    .clk(clk), .rst_n(rst_n), .start(ctl.div_start),
    .num(div_num), .done(div_done), .quo(quo)
  );

  assign in_ch.ready  = (st_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_free     = !ov_r || out_ch.ready;

  assign a1     = phase_r ? ay_r : ax_r;
  assign cnum   = phase_r ? ax_r : ay_r;
  assign raw_g  = (g_r == 2'd0) ? rx_r : (g_r == 2'd1) ? ry_r : rz_r;
  assign off_g  = (g_r == 2'd0) ? off_x_r : (g_r == 2'd1) ? off_y_r : off_z_r;
  assign prev_g = (g_r == 2'd0) ? filt_x_r : filt_y_r;
  assign ang_g  = (g_r == 2'd0) ? ang_x_r : ang_y_r;
  assign w_eff  = (weight_r > WEIGHT_ONE) ? WEIGHT_ONE : weight_r;
  assign gw     = WEIGHT_ONE - w_eff;
  assign mag    = prod_r[59] ? 60'(-prod_r) : 60'(prod_r);
  assign div_num = DIV_W'(mag) + DIV_HALF;
  assign rnd    = (prod_r + 60'(ANG_RND)) >>> ANG_SH;
  assign blend_sh = 48'((mac_r + 64'(prod_r) + 64'sd32768) >>> 16);
  assign zsum   = 48'(intz_r) + 48'(step_r);
  assign q_signed = neg_r ? -$signed(42'(quo)) : $signed(42'(quo));
  assign hz_sum = div_done ? 48'(intz_r) + 48'(q_signed) : zsum;
  assign res_load = (st_r == ST_DIV_W) && (div_done || div_hold_r) && (g_r == 2'd2)
                    && out_free;

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st_r)
      ST_SQ_A: begin
        mul_a = 35'(a1);
        mul_b = 25'(a1);
      end
      ST_SQ_B: begin
        mul_a = 35'(az_r);
        mul_b = 25'(az_r);
      end
      ST_G1: begin
        mul_a = 35'(raw_g);
        mul_b = $signed({1'b0, gain_r});
      end
      ST_G3: begin
        mul_a = 35'(rate_r);
        mul_b = $signed({9'b0, ms_r});
      end
      ST_B2: begin
        mul_a = $signed({14'b0, s_r[20:0]});
        mul_b = $signed({8'b0, gw});
      end
      ST_B3: begin
        mul_a = 35'($signed(s_r[42:21]));
        mul_b = $signed({8'b0, gw});
      end
      ST_B4: begin
        mul_a = 35'(ang_g);
        mul_b = $signed({8'b0, w_eff});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:   if (in_acc) st_nxt = ST_SQ_A;
      ST_SQ_A:   st_nxt = ST_SQ_B;
      ST_SQ_B:   st_nxt = ST_SQ_C;
      ST_SQ_C:   st_nxt = ST_SQRT_W;
      ST_SQRT_W: if (sq_done) st_nxt = ST_CORD_W;
      ST_CORD_W: if (cord_done) st_nxt = phase_r ? ST_G1 : ST_SQ_A;
      ST_G1:     st_nxt = ST_G2;
      ST_G2:     st_nxt = ST_G3;
      ST_G3:     st_nxt = ST_G4;
      ST_G4:     st_nxt = ST_DIV_W;
      ST_DIV_W: begin
        if (div_done || div_hold_r) begin
          if (g_r != 2'd2) begin
            st_nxt = ST_B1;
          end else if (out_free) begin
            st_nxt = ST_IDLE;
          end
        end
      end
      ST_B1:     st_nxt = ST_B2;
      ST_B2:     st_nxt = ST_B3;
      ST_B3:     st_nxt = ST_B4;
      ST_B4:     st_nxt = ST_B5;
      ST_B5:     st_nxt = ST_G1;
      default:   st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    unique case (st_r)
      ST_SQ_C:   ctl.sq_start = 1'b1;
      ST_SQRT_W: ctl.cord_start = sq_done;
      ST_G4:     ctl.div_start = 1'b1;
      default:   ctl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_IDLE;
      gain_r   <= 24'd256140;
      off_x_r  <= '0;
      off_y_r  <= '0;
      off_z_r  <= '0;
      weight_r <= 17'd1311;
      filt_x_r <= '0;
      filt_y_r <= '0;
      intz_r   <= '0;
      ov_r     <= 1'b0;
      div_hold_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_ch.valid) begin
        unique case (cfg_idx_t'(cfg_ch.index))
          REG_GAIN:   gain_r   <= cfg_ch.data[23:0];
          REG_OFF_X:  off_x_r  <= $signed(cfg_ch.data);
          REG_OFF_Y:  off_y_r  <= $signed(cfg_ch.data);
          REG_OFF_Z:  off_z_r  <= $signed(cfg_ch.data);
          REG_WEIGHT: weight_r <= cfg_ch.data[16:0];
          default: ;
        endcase
      end
      if (res_load) begin
        div_hold_r <= 1'b0;
        intz_r <= sat32(hz_sum);
        ov_r   <= 1'b1;
      end else begin
        if (ov_r && out_ch.ready) ov_r <= 1'b0;
        if (st_r == ST_DIV_W && div_done && g_r == 2'd2 && !out_free) begin
          div_hold_r <= 1'b1;
        end
      end
      if (st_r == ST_B5) begin
        if (g_r == 2'd0) filt_x_r <= sat32(blend_sh);
        else filt_y_r <= sat32(blend_sh);
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (in_acc) begin
      ax_r    <= in_ch.acc_x;
      ay_r    <= in_ch.acc_y;
      az_r    <= in_ch.acc_z;
      rx_r    <= in_ch.rate_x;
      ry_r    <= in_ch.rate_y;
      rz_r    <= in_ch.rate_z;
      ms_r    <= in_ch.elapsed_ms;
      phase_r <= 1'b0;
      g_r     <= 2'd0;
    end
    case (st_r)
      ST_SQ_B: mac_r <= 64'(prod_r);
      ST_CORD_W: begin
        if (cord_done) begin
          if (phase_r) ang_y_r <= -angle;
          else ang_x_r <= angle;
          phase_r <= 1'b1;
        end
      end
      ST_G2: rate_r <= 34'(rnd) - 34'(off_g);
      ST_G4: neg_r <= prod_r[59];
      ST_DIV_W: if (div_done) step_r <= q_signed;
      ST_B1: s_r <= 43'(prev_g) + 43'(step_r);
      ST_B3: mac_r <= 64'(prod_r);
      ST_B4: mac_r <= mac_r + (64'(prod_r) <<< 21);
      ST_B5: begin
        mac_r <= mac_r + 64'(prod_r);
        g_r   <= g_r + 2'd1;
      end
      default: ;
    endcase
    if (res_load) begin
      o_tx_r <= filt_x_r;
      o_ty_r <= filt_y_r;
      o_hz_r <= sat32(hz_sum);
      o_ax_r <= ang_x_r;
      o_ay_r <= ang_y_r;
    end
  end

  assign out_ch.valid      = ov_r;
  assign out_ch.tilt_x     = o_tx_r;
  assign out_ch.tilt_y     = o_ty_r;
  assign out_ch.heading_z  = o_hz_r;
  assign out_ch.acc_tilt_x = o_ax_r;
  assign out_ch.acc_tilt_y = o_ay_r;
endmodule

// File: rtl/ict_isqrt.sv
// Bit-serial integer floor square root, one result bit per step.
module ict_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] v,
  output logic        done,
  output logic [15:0] root
);
  import ict_pkg::*;

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [31:0] v_r, v_nxt;
  logic [31:0] r_r, r_nxt;
  logic [30:0] bit_r, bit_nxt;
  logic [31:0] t;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    v_nxt    = v_r;
    r_nxt    = r_r;
    bit_nxt  = bit_r;
    t        = r_r + {1'b0, bit_r};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      v_nxt    = v;
      r_nxt    = '0;
      bit_nxt  = 31'h40000000;
    end else if (busy_r) begin
      if (v_r >= t) begin
        v_nxt = v_r - t;
        r_nxt = (r_r >> 1) + {1'b0, bit_r};
      end else begin
        r_nxt = r_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      cnt_nxt = cnt_r + 4'd1;
      if (cnt_r == 4'(SQRT_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    v_r   <= v_nxt;
    r_r   <= r_nxt;
    bit_r <= bit_nxt;
  end

  assign done = done_r;
  assign root = r_r[15:0];
endmodule

// File: rtl/ict_cordic.sv
// Vectoring CORDIC atan2 in degrees, one micro-rotation per cycle.
module ict_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [15:0] num,
  input  logic [15:0]        den,
  output logic               done,
  output logic signed [24:0] angle
);
  import ict_pkg::*;

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [4:0]         i_r, i_nxt;
  logic signed [39:0] x_r, x_nxt, y_r, y_nxt, dx, dy;
  logic signed [32:0] z_r, z_nxt;
  logic signed [24:0] ang_r, ang_nxt;

  function automatic logic signed [24:0] finish(input logic signed [32:0] z);
    logic signed [32:0] zc;
    logic signed [32:0] zr;
    zc = z;
    if (zc > DEG90_Q24) zc = DEG90_Q24;
    if (zc < -DEG90_Q24) zc = -DEG90_Q24;
    zr = (zc + 33'(ANG_RND)) >>> ANG_SH;
    finish = 25'(zr);
  endfunction

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    i_nxt    = i_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    ang_nxt  = ang_r;
    dx       = y_r >>> i_r;
    dy       = x_r >>> i_r;
    if (start) begin
      i_nxt = '0;
      x_nxt = $signed({4'b0, den, 20'b0});
      y_nxt = $signed({{4{num[15]}}, num, 20'b0});
      z_nxt = '0;
      if (num == 16'sd0) begin
        ang_nxt  = '0;
        done_nxt = 1'b1;
      end else if (den == 16'd0) begin
        ang_nxt  = finish(num[15] ? -DEG90_Q24 : DEG90_Q24);
        done_nxt = 1'b1;
      end else begin
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      if (!y_r[39]) begin
        x_nxt = x_r + dx;
        y_nxt = y_r - dy;
        z_nxt = z_r + atan_q24(i_r);
      end else begin
        x_nxt = x_r - dx;
        y_nxt = y_r + dy;
        z_nxt = z_r - atan_q24(i_r);
      end
      i_nxt = i_r + 5'd1;
      if (i_r == 5'(CORDIC_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        ang_nxt  = finish(z_nxt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    i_r   <= i_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
    ang_r <= ang_nxt;
  end

  assign done  = done_r;
  assign angle = ang_r;
endmodule

// File: rtl/ict_div1000.sv
// Divider by the constant 1000, one 16-bit quotient digit per cycle by reciprocal multiply.
module ict_div1000 (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [ict_pkg::DIV_W-1:0] num,
  output logic                      done,
  output logic [ict_pkg::DIV_W-1:0] quo
);
  import ict_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS);

  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [DIV_PAD_W-1:0]   num_r, num_nxt;
  logic [DIV_W-1:0]       q_r, q_nxt;
  logic [DIV_REM_W-1:0]   rem_r, rem_nxt;
  logic [DIV_VAL_W-1:0]   val, qk;
  logic [DIV_VAL_W+26:0]  prod;
  logic [DIV_DIG_W-1:0]   qd;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    val      = {rem_r, num_r[DIV_PAD_W-1 -: DIV_DIG_W]};
    prod     = val * DIV_RECIP;
    qd       = prod[DIV_RECIP_SH +: DIV_DIG_W];
    qk       = {qd, 10'b0} - {6'b0, qd, 4'b0} - {7'b0, qd, 3'b0};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      num_nxt  = DIV_PAD_W'(num);
      q_nxt    = '0;
      rem_nxt  = '0;
    end else if (busy_r) begin
      num_nxt = num_r << DIV_DIG_W;
      rem_nxt = DIV_REM_W'(val - qk);
      q_nxt   = DIV_W'({q_r, qd});
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    num_r <= num_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;
endmodule

// File: rtl/ict_checker.sv
// Port-level checks of the tilt filter, bound to the top level.
module ict_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_tilt_x
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_tilt_x))
    else $error("stalled result word changed");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a sample is in work");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word present after reset");

endmodule

bind imu_complementary_tilt_filter ict_checker u_ict_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_tilt_x(out_ch.tilt_x)
);
